FILE: rtl/mmtm_pkg.sv
// Shared constants and types for the min-max tone mapper.
package mmtm_pkg;

    localparam int LANES       = 3;
    localparam int OUT_BITS    = 8;
    localparam int STEP_BITS   = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [OUT_BITS-1:0]  BYTE_MAX  = 8'd255;
    localparam logic [STEP_BITS-1:0] STEP_LAST = 3'd7;
    localparam logic [STEP_BITS-1:0] STEP_ZERO = 3'd0;

    // Per-pixel control handed from the front end to the back end.
    typedef struct packed {
        logic normalize;
        logic empty_range;
    } map_ctrl_t;

endpackage

FILE: rtl/mmtm_front.sv
// Front end: accepts words, tracks the running minimum and maximum, queues map pixels.
module mmtm_front #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_normalize_mode,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_kind,
    input  logic                   s_first_pixel,
    input  logic [SAMPLE_BITS-1:0] s_red_in,
    input  logic [SAMPLE_BITS-1:0] s_green_in,
    input  logic [SAMPLE_BITS-1:0] s_blue_in,
    input  logic                   q_full,
    output logic                   q_push,
    output mmtm_pkg::map_ctrl_t    q_ctrl,
    output logic [SAMPLE_BITS-1:0] q_min,
    output logic [SAMPLE_BITS-1:0] q_span,
    output logic [SAMPLE_BITS-1:0] q_red,
    output logic [SAMPLE_BITS-1:0] q_green,
    output logic [SAMPLE_BITS-1:0] q_blue
);

    logic                   mode_reg;
    logic [SAMPLE_BITS-1:0] min_reg, min_next;
    logic [SAMPLE_BITS-1:0] max_reg, max_next;
    logic [SAMPLE_BITS-1:0] lo_rg, hi_rg, lo, hi;
    logic                   accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign q_push    = accept && s_kind;

    always_comb begin
        lo_rg = (s_green_in < s_red_in) ? s_green_in : s_red_in;
        hi_rg = (s_green_in > s_red_in) ? s_green_in : s_red_in;
        lo    = (s_blue_in < lo_rg) ? s_blue_in : lo_rg;
        hi    = (s_blue_in > hi_rg) ? s_blue_in : hi_rg;
        min_next = min_reg;
        max_next = max_reg;
        if (accept && !s_kind) begin
            if (s_first_pixel) begin
                min_next = lo;
                max_next = hi;
            end else begin
                if (lo < min_reg) min_next = lo;
                if (hi > max_reg) max_next = hi;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b1;
            min_reg  <= {SAMPLE_BITS{1'b1}};
            max_reg  <= '0;
        end else begin
            if (cfg_valid) mode_reg <= cfg_normalize_mode;
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

    // The range is snapshotted with each pixel so later gathers cannot disturb it.
    assign q_ctrl.normalize   = mode_reg;
    assign q_ctrl.empty_range = (max_reg <= min_reg);
    assign q_min   = min_reg;
    assign q_span  = max_reg - min_reg;
    assign q_red   = s_red_in;
    assign q_green = s_green_in;
    assign q_blue  = s_blue_in;

endmodule

FILE: rtl/mmtm_queue.sv
// Small first-in first-out queue between the front end and the back end.
module mmtm_queue #(
    parameter int WIDTH = 66
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0]              mem [mmtm_pkg::QUEUE_DEPTH];
    logic [mmtm_pkg::QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [mmtm_pkg::QUEUE_AW:0]   count_reg;

    localparam logic [mmtm_pkg::QUEUE_AW:0] DEPTH_CNT =
        (mmtm_pkg::QUEUE_AW+1)'(mmtm_pkg::QUEUE_DEPTH);

    assign full      = (count_reg == DEPTH_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

FILE: rtl/mmtm_back.sv
// Back end: per-channel mapping with a shared restoring-division sequencer.
module mmtm_back #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  mmtm_pkg::map_ctrl_t    in_ctrl,
    input  logic [SAMPLE_BITS-1:0] in_min,
    input  logic [SAMPLE_BITS-1:0] in_span,
    input  logic [SAMPLE_BITS-1:0] in_red,
    input  logic [SAMPLE_BITS-1:0] in_green,
    input  logic [SAMPLE_BITS-1:0] in_blue,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [mmtm_pkg::OUT_BITS-1:0] m_red_out,
    output logic [mmtm_pkg::OUT_BITS-1:0] m_green_out,
    output logic [mmtm_pkg::OUT_BITS-1:0] m_blue_out
);

    localparam int WIDE = SAMPLE_BITS + mmtm_pkg::OUT_BITS;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DIVIDE = 3'b010,
        ST_FINISH = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;
    logic [mmtm_pkg::STEP_BITS-1:0] step_reg;
    logic [SAMPLE_BITS-1:0]         span_reg;
    logic [WIDE-1:0]                rem_reg [mmtm_pkg::LANES];
    logic [mmtm_pkg::OUT_BITS-1:0]  quo_reg [mmtm_pkg::LANES];
    logic                           fix_reg [mmtm_pkg::LANES];
    logic [mmtm_pkg::OUT_BITS-1:0]  out_reg [mmtm_pkg::LANES];
    logic                           out_valid_reg;

    logic [SAMPLE_BITS-1:0]         pix   [mmtm_pkg::LANES];
    logic [WIDE-1:0]                rem_init [mmtm_pkg::LANES];
    logic [mmtm_pkg::OUT_BITS-1:0]  fix_val  [mmtm_pkg::LANES];
    logic                           fix_init [mmtm_pkg::LANES];
    logic [WIDE-1:0]                rem_step [mmtm_pkg::LANES];
    logic [mmtm_pkg::OUT_BITS-1:0]  quo_step [mmtm_pkg::LANES];
    logic [WIDE-1:0]                div_shift;

    logic load, out_free;

    assign pix[0] = in_red;
    assign pix[1] = in_green;
    assign pix[2] = in_blue;

    assign in_ready = (state_reg == ST_IDLE);
    assign load     = in_valid && in_ready;
    assign out_free = !out_valid_reg || m_ready;
    assign div_shift = {{mmtm_pkg::OUT_BITS{1'b0}}, span_reg} << step_reg;

    for (genvar l = 0; l < mmtm_pkg::LANES; l++) begin : g_lane
        logic [SAMPLE_BITS-1:0] diff;
        logic [WIDE-1:0]        pix_x255, diff_x255, clamp_scaled;
        logic                   ge_one;

        if (FRAC_BITS >= SAMPLE_BITS) begin : g_no_one
            assign ge_one = 1'b0;
        end else begin : g_one
            assign ge_one = |pix[l][SAMPLE_BITS-1:FRAC_BITS];
        end

        assign diff         = pix[l] - in_min;
        assign pix_x255     = ({{mmtm_pkg::OUT_BITS{1'b0}}, pix[l]} << mmtm_pkg::OUT_BITS)
                              - {{mmtm_pkg::OUT_BITS{1'b0}}, pix[l]};
        assign diff_x255    = ({{mmtm_pkg::OUT_BITS{1'b0}}, diff} << mmtm_pkg::OUT_BITS)
                              - {{mmtm_pkg::OUT_BITS{1'b0}}, diff};
        assign clamp_scaled = pix_x255 >> FRAC_BITS;
        assign rem_init[l]  = diff_x255;

        always_comb begin
            fix_init[l] = 1'b1;
            fix_val[l]  = '0;
            if (!in_ctrl.normalize) begin
                fix_val[l] = ge_one ? mmtm_pkg::BYTE_MAX
                                    : clamp_scaled[mmtm_pkg::OUT_BITS-1:0];
            end else if (in_ctrl.empty_range || pix[l] <= in_min) begin
                fix_val[l] = '0;
            end else if (diff >= in_span) begin
                // At or above the gathered maximum the quotient saturates.
                fix_val[l] = mmtm_pkg::BYTE_MAX;
            end else begin
                fix_init[l] = 1'b0;
            end
        end

        always_comb begin
            rem_step[l] = rem_reg[l];
            quo_step[l] = quo_reg[l];
            if (!fix_reg[l] && rem_reg[l] >= div_shift) begin
                rem_step[l] = rem_reg[l] - div_shift;
                quo_step[l][step_reg] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (load) begin
                rem_reg[l] <= rem_init[l];
                fix_reg[l] <= fix_init[l];
                quo_reg[l] <= fix_val[l];
            end else if (state_reg == ST_DIVIDE) begin
                rem_reg[l] <= rem_step[l];
                quo_reg[l] <= quo_step[l];
            end
            if (state_reg == ST_FINISH && out_free) out_reg[l] <= quo_reg[l];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_DIVIDE;
            ST_DIVIDE: if (step_reg == mmtm_pkg::STEP_ZERO) state_next = ST_FINISH;
            ST_FINISH: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            span_reg <= in_span;
            step_reg <= mmtm_pkg::STEP_LAST;
        end else if (state_reg == ST_DIVIDE) begin
            step_reg <= step_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_FINISH && out_free) out_valid_reg <= 1'b1;
            else if (m_ready)                       out_valid_reg <= 1'b0;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_red_out   = out_reg[0];
    assign m_green_out = out_reg[1];
    assign m_blue_out  = out_reg[2];

endmodule

FILE: rtl/minmax_tone_map.sv
// Top level of the min-max tone mapper: front end, pixel queue and back end.
//
// The block turns unsigned fixed-point RGB radiance (FRAC_BITS fraction bits in a
// SAMPLE_BITS word) into 8-bit RGB. A frame is streamed twice: gather words (kind 0)
// update one running minimum and maximum over all three channels and give no result,
// with first_pixel restarting the range; map words (kind 1) each give one output word.
// Gather words are taken one per clock while the queue is not full. Each map word
// occupies the back end for a load, eight restoring-division steps and a hand-off
// into the output register, which waits while the output is stalled. The back end
// takes no new map word until the last one is handed off, so the shared divide
// sequencer in the back end limits the map rate. A four-word queue between the
// front and back ends carries each map pixel together with the range that was in
// force when it arrived, so gathers keep flowing while the back end works. The
// normalize_mode register resets to 1 and is written through the cfg channel; the
// user must write it only while the block is idle, which the block does not enforce.
module minmax_tone_map #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_normalize_mode,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_kind,
    input  logic                   s_first_pixel,
    input  logic [SAMPLE_BITS-1:0] s_red_in,
    input  logic [SAMPLE_BITS-1:0] s_green_in,
    input  logic [SAMPLE_BITS-1:0] s_blue_in,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [mmtm_pkg::OUT_BITS-1:0] m_red_out,
    output logic [mmtm_pkg::OUT_BITS-1:0] m_green_out,
    output logic [mmtm_pkg::OUT_BITS-1:0] m_blue_out
);

    localparam int CTRL_BITS = $bits(mmtm_pkg::map_ctrl_t);
    localparam int Q_WIDTH   = CTRL_BITS + 5 * SAMPLE_BITS;

    // Front-end outputs toward the queue.
    logic                   q_full, q_push;
    mmtm_pkg::map_ctrl_t    f_ctrl;
    logic [SAMPLE_BITS-1:0] f_min, f_span, f_red, f_green, f_blue;

    // Queue outputs toward the back end.
    logic                   q_not_empty, q_pop;
    logic [Q_WIDTH-1:0]     q_in, q_out;
    mmtm_pkg::map_ctrl_t    b_ctrl;
    logic [SAMPLE_BITS-1:0] b_min, b_span, b_red, b_green, b_blue;
    logic                   b_ready;

    mmtm_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_normalize_mode (cfg_normalize_mode),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_first_pixel      (s_first_pixel),
        .s_red_in           (s_red_in),
        .s_green_in         (s_green_in),
        .s_blue_in          (s_blue_in),
        .q_full             (q_full),
        .q_push             (q_push),
        .q_ctrl             (f_ctrl),
        .q_min              (f_min),
        .q_span             (f_span),
        .q_red              (f_red),
        .q_green            (f_green),
        .q_blue             (f_blue)
    );

    // Each queue entry holds the pixel plus the range snapshot taken at acceptance.
    assign q_in = {f_ctrl, f_min, f_span, f_red, f_green, f_blue};

    mmtm_queue #(
        .WIDTH (Q_WIDTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_out)
    );

    assign {b_ctrl, b_min, b_span, b_red, b_green, b_blue} = q_out;
    assign q_pop = q_not_empty && b_ready;

    mmtm_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (q_not_empty),
        .in_ready    (b_ready),
        .in_ctrl     (b_ctrl),
        .in_min      (b_min),
        .in_span     (b_span),
        .in_red      (b_red),
        .in_green    (b_green),
        .in_blue     (b_blue),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red_out   (m_red_out),
        .m_green_out (m_green_out),
        .m_blue_out  (m_blue_out)
    );

endmodule

FILE: dv/tb_minmax_tone_map.sv
// Self-checking testbench for the min-max tone mapper, driven through its word channels.
`timescale 1ns / 100ps

module tb_minmax_tone_map;

    localparam int SAMPLE_W = 16;
    localparam int FRAC_W   = 12;
    localparam int unsigned ONE_Q = 1 << FRAC_W;

    // Word kinds on the input channel.
    localparam logic KIND_GATHER = 1'b0;
    localparam logic KIND_MAP    = 1'b1;

    // Settings of the normalize_mode register.
    localparam logic MODE_CLAMP     = 1'b0;
    localparam logic MODE_NORMALIZE = 1'b1;

    // Cycles allowed after the last result before the block counts as idle. The back end
    // takes map words one at a time, and trailing gather words may still be in flight.
    localparam int SETTLE_CYCLES = 30;

    typedef struct packed {
        logic [mmtm_pkg::OUT_BITS-1:0] red;
        logic [mmtm_pkg::OUT_BITS-1:0] green;
        logic [mmtm_pkg::OUT_BITS-1:0] blue;
    } rgb8_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic                   cfg_normalize_mode;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_kind;
    logic                   s_first_pixel;
    logic [SAMPLE_W-1:0]    s_red_in;
    logic [SAMPLE_W-1:0]    s_green_in;
    logic [SAMPLE_W-1:0]    s_blue_in;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [mmtm_pkg::OUT_BITS-1:0] m_red_out;
    logic [mmtm_pkg::OUT_BITS-1:0] m_green_out;
    logic [mmtm_pkg::OUT_BITS-1:0] m_blue_out;

    // Shadow copy of the block's register and range state, kept in step with accepted words.
    logic                normalize_q = MODE_NORMALIZE;
    logic [SAMPLE_W-1:0] range_lo    = '1;
    logic [SAMPLE_W-1:0] range_hi    = '0;

    // Output pixels that are owed by the block, oldest first.
    rgb8_t pending_rgb[$];
    rgb8_t want_rgb;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;

    int errors       = 0;
    int gathers_sent = 0;
    int maps_sent    = 0;
    int results_seen = 0;
    int mode_writes  = 0;

    minmax_tone_map #(
        .SAMPLE_BITS(SAMPLE_W),
        .FRAC_BITS  (FRAC_W)
    ) uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_normalize_mode(cfg_normalize_mode),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_first_pixel     (s_first_pixel),
        .s_red_in          (s_red_in),
        .s_green_in        (s_green_in),
        .s_blue_in         (s_blue_in),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_red_out         (m_red_out),
        .m_green_out       (m_green_out),
        .m_blue_out        (m_blue_out)
    );

    // 20 ns clock: low for the first half period, then high.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Expected byte for one channel sample under the current mode and range.
    function automatic logic [mmtm_pkg::OUT_BITS-1:0] tone_byte(
            input logic [SAMPLE_W-1:0] x);
        int unsigned num;
        int unsigned den;
        int unsigned q;
        if (normalize_q == MODE_CLAMP) begin
            // Anything at or above 1.0 saturates; below that the scale is x * 255 / 2^FRAC.
            if (x >= ONE_Q)
                return mmtm_pkg::BYTE_MAX;
            q = x;
            q = (q * mmtm_pkg::BYTE_MAX) >> FRAC_W;
            return q[mmtm_pkg::OUT_BITS-1:0];
        end
        // An empty range maps everything to zero, and so does anything at or below the minimum.
        if (range_hi <= range_lo || x <= range_lo)
            return '0;
        num = x;
        num = (num - range_lo) * mmtm_pkg::BYTE_MAX;
        den = range_hi;
        den = den - range_lo;
        q   = num / den;
        if (q > mmtm_pkg::BYTE_MAX)
            return mmtm_pkg::BYTE_MAX;
        return q[mmtm_pkg::OUT_BITS-1:0];
    endfunction

    // The receiver either holds off for a counted stretch or stalls at random per cycle.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic check_byte(input string chan, input logic [mmtm_pkg::OUT_BITS-1:0] want,
                              input logic [mmtm_pkg::OUT_BITS-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, chan, want, got);
            errors++;
        end
    endtask

    // Every result word taken from the block is matched against the oldest owed pixel.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_rgb.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %0d %0d %0d",
                         $time, m_red_out, m_green_out, m_blue_out);
                errors++;
            end else begin
                want_rgb = pending_rgb.pop_front();
                check_byte("red", want_rgb.red, m_red_out);
                check_byte("green", want_rgb.green, m_green_out);
                check_byte("blue", want_rgb.blue, m_blue_out);
                results_seen++;
            end
        end
    end

    // Offers one word and waits for it to be taken. Starts and ends at a falling edge;
    // the shadow state is updated at the accepting edge so the prediction sees the same
    // range and mode that the block captured with the word.
    task automatic send_pixel(input logic kind, input logic first,
                              input logic [SAMPLE_W-1:0] r,
                              input logic [SAMPLE_W-1:0] g,
                              input logic [SAMPLE_W-1:0] b);
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_first_pixel <= first;
        s_red_in      <= r;
        s_green_in    <= g;
        s_blue_in     <= b;
        do @(posedge aclk); while (!s_ready);
        if (kind == KIND_MAP) begin
            pending_rgb.push_back('{red: tone_byte(r), green: tone_byte(g), blue: tone_byte(b)});
            maps_sent++;
        end else begin
            lo = r;
            hi = r;
            if (g < lo) lo = g;
            if (b < lo) lo = b;
            if (g > hi) hi = g;
            if (b > hi) hi = b;
            // A first pixel restarts the range; otherwise the range only widens.
            if (first) begin
                range_lo = lo;
                range_hi = hi;
            end else begin
                if (lo < range_lo) range_lo = lo;
                if (hi > range_hi) range_hi = hi;
            end
            gathers_sent++;
        end
        @(negedge aclk);
    endtask

    // Drops valid and waits until every owed pixel has come out and the pipeline is quiet.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_rgb.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Writes normalize_mode; only called right after wait_idle.
    task automatic write_mode(input logic mode);
        cfg_valid          <= 1'b1;
        cfg_normalize_mode <= mode;
        do @(posedge aclk); while (!cfg_ready);
        normalize_q = mode;
        mode_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Right after reset the range is empty, so normalize mode must give all zeros. The
    // first-pixel flag on a map word has no effect.
    task automatic test_map_after_reset();
        send_pixel(KIND_MAP, 1'b1, 16'd0, 16'd0, 16'd0);
        send_pixel(KIND_MAP, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(KIND_MAP, 1'b1, 16'd4096, 16'd1, 16'hFFFE);
        wait_idle();
    endtask

    // Normalize mode at the edges of the gathered range, outside it, with an empty range
    // and with a range that spans the whole sample word.
    task automatic test_normalize_edges();
        send_pixel(KIND_GATHER, 1'b1, 16'd100, 16'd200, 16'd300);
        send_pixel(KIND_GATHER, 1'b0, 16'd50, 16'd4000, 16'd150);
        send_pixel(KIND_MAP, 1'b0, 16'd50, 16'd4000, 16'd2025);
        send_pixel(KIND_MAP, 1'b1, 16'd0, 16'hFFFF, 16'd51);
        send_pixel(KIND_MAP, 1'b0, 16'd3999, 16'd4001, 16'd49);
        // One gray pixel leaves max equal to min.
        send_pixel(KIND_GATHER, 1'b1, 16'd777, 16'd777, 16'd777);
        send_pixel(KIND_MAP, 1'b0, 16'd777, 16'd778, 16'hFFFF);
        // A later gather without the flag widens the range again.
        send_pixel(KIND_GATHER, 1'b0, 16'd0, 16'hFFFF, 16'd1);
        send_pixel(KIND_MAP, 1'b0, 16'hFFFF, 16'd0, 16'h8000);
        send_pixel(KIND_MAP, 1'b0, 16'd1, 16'hFFFE, 16'h7FFF);
        wait_idle();
    endtask

    // Clamp mode around 1.0 and at the extremes, then back to normalize.
    task automatic test_clamp_edges();
        write_mode(MODE_CLAMP);
        send_pixel(KIND_MAP, 1'b0, 16'd0, 16'd4095, 16'd4096);
        send_pixel(KIND_MAP, 1'b1, 16'hFFFF, 16'd1, 16'd2048);
        send_pixel(KIND_MAP, 1'b0, 16'd17, 16'd4097, 16'hAAAA);
        wait_idle();
        write_mode(MODE_NORMALIZE);
    endtask

    // Holds the receiver off for a long stretch while map words keep coming, so the pixel
    // queue fills and the block must stall its input.
    task automatic test_output_backpressure();
        int k;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_pixel(KIND_GATHER, 1'b1, 16'd1000, 16'd20000, 16'd5000);
        hold_left = 400;
        for (k = 0; k < 30; k++)
            send_pixel(KIND_MAP, 1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
        wait_idle();
    endtask

    // Random frames: mostly a gather pass followed by a map pass over the same pixels,
    // with some noise words of any kind mixed in between frames.
    task automatic test_random_frames(input int n_words, input int idle_pct,
                                      input int stall_pct);
        logic [SAMPLE_W-1:0] px [0:15][0:2];
        int sent;
        int n;
        int k;
        int c;
        int base;
        int span;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_words) begin
            n = $urandom_range(16, 1);
            case ($urandom_range(3))
                0: begin base = 0; span = 65535; end
                1: begin base = $urandom_range(65535); span = $urandom_range(64); end
                2: begin base = 0; span = 8191; end
                default: begin base = $urandom_range(65535); span = $urandom_range(65535); end
            endcase
            if (base + span > 65535)
                span = 65535 - base;
            for (k = 0; k < n; k++)
                for (c = 0; c < 3; c++)
                    px[k][c] = SAMPLE_W'(base + $urandom_range(span));
            if ($urandom_range(9) < 8) begin
                for (k = 0; k < n; k++)
                    send_pixel(KIND_GATHER, k == 0, px[k][0], px[k][1], px[k][2]);
                for (k = 0; k < n; k++)
                    send_pixel(KIND_MAP, 1'($urandom), px[k][0], px[k][1], px[k][2]);
                sent += 2 * n;
            end else begin
                for (k = 0; k < n; k++)
                    send_pixel(1'($urandom), 1'($urandom), px[k][0], px[k][1], px[k][2]);
                sent += n;
            end
        end
        wait_idle();
    endtask

    initial begin
        aresetn            = 1'b0;
        cfg_valid          = 1'b0;
        cfg_normalize_mode = 1'b0;
        s_valid            = 1'b0;
        s_kind             = KIND_GATHER;
        s_first_pixel      = 1'b0;
        s_red_in           = '0;
        s_green_in         = '0;
        s_blue_in          = '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_map_after_reset();
        test_normalize_edges();
        test_clamp_edges();
        test_output_backpressure();

        // Each idle pattern runs once in each mode.
        test_random_frames(225, 0, 0);
        write_mode(MODE_CLAMP);
        test_random_frames(225, 0, 0);
        write_mode(MODE_NORMALIZE);
        test_random_frames(225, 74, 0);
        write_mode(MODE_CLAMP);
        test_random_frames(225, 74, 0);
        test_random_frames(225, 0, 74);
        write_mode(MODE_NORMALIZE);
        test_random_frames(225, 0, 74);
        test_random_frames(225, 19, 19);
        write_mode(MODE_CLAMP);
        test_random_frames(225, 19, 19);

        $display("Covered %0d gather words and %0d map words, %0d results checked,",
                 gathers_sent, maps_sent, results_seen);
        $display("%0d mode writes, idle and stall patterns on both channels, long hold-off.",
                 mode_writes);
        if (errors == 0) begin
            $display("tb_minmax_tone_map: done, clean");
        end else begin
            $display("tb_minmax_tone_map: done, errors");
        end
        $finish;
    end

    // Watchdog: a correct run needs a small fraction of this.
    initial begin
        #20_000_000;
        $display("tb_minmax_tone_map: done, errors");
        $finish;
    end

endmodule

FILE: minmax_tone_map.f
rtl/mmtm_pkg.sv
rtl/mmtm_front.sv
rtl/mmtm_queue.sv
rtl/mmtm_back.sv
rtl/minmax_tone_map.sv
dv/tb_minmax_tone_map.sv
